// ----- design/affine_cell_warp_bilinear_macros.svh -----
// assertion macros for the affine cell warp block
`ifndef AFFINE_CELL_WARP_BILINEAR_MACROS_SVH
`define AFFINE_CELL_WARP_BILINEAR_MACROS_SVH

// same-cycle implication, checked outside reset
`define ACWB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ACWB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/acwb_pkg.sv -----
// shared constants and codes for the affine cell warp block
package acwb_pkg;

    localparam int CELL_SIZE_DEF  = 10;
    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int REG_W     = 32;
    localparam int CH_W      = 8;
    localparam int PIX_W     = 3 * CH_W;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCALE_XX = 3'd0,
        CFG_SCALE_XY = 3'd1,
        CFG_OFFSET_X = 3'd2,
        CFG_SCALE_YX = 3'd3,
        CFG_SCALE_YY = 3'd4,
        CFG_OFFSET_Y = 3'd5
    } cfg_idx_t;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_WARP = 1'b1;

    localparam logic [REG_W-1:0] SCALE_ONE_RST = 32'h0001_0000;

endpackage

// ----- design/acwb_ram.sv -----
// generic synchronous ram, one write port and two registered read ports
module acwb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 121,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// ----- design/acwb_blend.sv -----
// bilinear weights, per-channel rounded terms, sum and saturation, output register
module acwb_blend #(
    parameter int COORD_BITS = acwb_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = acwb_pkg::FRAC_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       c_valid,
    input  logic                       c_inside,
    input  logic [FRAC_BITS-1:0]       c_fx,
    input  logic [FRAC_BITS-1:0]       c_fy,
    input  logic [COORD_BITS-1:0]      c_dx,
    input  logic [COORD_BITS-1:0]      c_dy,
    input  logic [acwb_pkg::PIX_W-1:0] p00,
    input  logic [acwb_pkg::PIX_W-1:0] p01,
    input  logic [acwb_pkg::PIX_W-1:0] p10,
    input  logic [acwb_pkg::PIX_W-1:0] p11,
    output logic                       out_valid,
    output logic                       write_valid,
    output logic [COORD_BITS-1:0]      out_x,
    output logic [COORD_BITS-1:0]      out_y,
    output logic [acwb_pkg::CH_W-1:0]  out_red,
    output logic [acwb_pkg::CH_W-1:0]  out_green,
    output logic [acwb_pkg::CH_W-1:0]  out_blue
);
    import acwb_pkg::*;

    localparam int GW = FRAC_BITS + 1;
    localparam int WW = 2 * GW;
    localparam int TW = WW + CH_W;
    localparam int SUM_W = CH_W + 2;
    localparam logic [GW-1:0] ONE = GW'(1) << FRAC_BITS;
    localparam logic [TW-1:0] HALF = TW'(1) << (2 * FRAC_BITS - 1);

    // corner order: 00, 01, 10, 11
    logic [GW-1:0]    fx_w, fy_w, gx_w, gy_w;
    logic [WW-1:0]    w_next [4];
    logic [WW-1:0]    w_reg [4];
    logic [PIX_W-1:0] dp_reg [4];
    logic             d_valid_reg, d_inside_reg;
    logic [COORD_BITS-1:0] d_dx_reg, d_dy_reg;

    logic [CH_W-1:0]  t_next [4][3];
    logic [CH_W-1:0]  t_reg [4][3];
    logic             e_valid_reg, e_inside_reg;
    logic [COORD_BITS-1:0] e_dx_reg, e_dy_reg;

    logic [SUM_W-1:0] sum_w [3];
    logic [CH_W-1:0]  ch_next [3];
    logic             out_valid_reg, write_valid_reg;
    logic [COORD_BITS-1:0] out_x_reg, out_y_reg;
    logic [CH_W-1:0]  ch_reg [3];

    always_comb
    begin
        fx_w = {1'b0, c_fx};
        fy_w = {1'b0, c_fy};
        gx_w = ONE - fx_w;
        gy_w = ONE - fy_w;
        w_next[0] = WW'(gx_w) * WW'(gy_w);
        w_next[1] = WW'(fx_w) * WW'(gy_w);
        w_next[2] = WW'(gx_w) * WW'(fy_w);
        w_next[3] = WW'(fx_w) * WW'(fy_w);
    end

    // one product per corner and channel, rounded half up
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                t_next[k][c] = CH_W'((TW'(dp_reg[k][(2-c)*CH_W +: CH_W]) * TW'(w_reg[k])
                                      + HALF) >> (2 * FRAC_BITS));
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            sum_w[c] = SUM_W'(t_reg[0][c]) + SUM_W'(t_reg[1][c])
                     + SUM_W'(t_reg[2][c]) + SUM_W'(t_reg[3][c]);
            if (!e_inside_reg)
            begin
                ch_next[c] = '0;
            end
            else if (sum_w[c] > SUM_W'(8'hFF))
            begin
                ch_next[c] = 8'hFF;
            end
            else
            begin
                ch_next[c] = sum_w[c][CH_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg   <= 1'b0;
            e_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            d_valid_reg   <= c_valid;
            e_valid_reg   <= d_valid_reg;
            out_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_reg           <= w_next;
            dp_reg[0]       <= p00;
            dp_reg[1]       <= p01;
            dp_reg[2]       <= p10;
            dp_reg[3]       <= p11;
            d_inside_reg    <= c_inside;
            d_dx_reg        <= c_dx;
            d_dy_reg        <= c_dy;
            t_reg           <= t_next;
            e_inside_reg    <= d_inside_reg;
            e_dx_reg        <= d_dx_reg;
            e_dy_reg        <= d_dy_reg;
            ch_reg          <= ch_next;
            write_valid_reg <= e_inside_reg;
            out_x_reg       <= e_dx_reg;
            out_y_reg       <= e_dy_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign write_valid = write_valid_reg;
    assign out_x       = out_x_reg;
    assign out_y       = out_y_reg;
    assign out_red     = ch_reg[0];
    assign out_green   = ch_reg[1];
    assign out_blue    = ch_reg[2];

endmodule

// ----- design/affine_cell_warp_bilinear.sv -----
// top level of the affine cell warp block with bilinear blend
// Warps one cell of a source image: load transfers (operation 0) write one pixel of the
// (CELL_SIZE+1)^2 tile into two mirrored tile rams and give no result; the write is carried
// two pipeline steps behind the transfer so that it lands at the same step as the tile read
// of a warp, which keeps loads and warps in transfer order. Warp transfers (operation 1)
// give exactly one result each, in order. The block takes one transfer per clock whenever
// the result side is not stalled. On the way to a warp result, the products are registered
// at the accepting edge, then the sums, then a ram read step that also does the cell range
// check, then weights, rounded per-channel terms and the saturating sum. The rate is set by
// the ram, which serves the four corners of a warp in a single read: the upper ram copy
// reads the corner pair of row y0, the lower copy that of row y0+1. A load is visible to any
// warp accepted after it and to none accepted before it. The whole pipeline moves together;
// when a result is held by stall, the input side is stalled in the same cycle. Configuration
// writes are taken at any time but must only be made while the pipeline is empty.
module affine_cell_warp_bilinear #(
    parameter int CELL_SIZE  = acwb_pkg::CELL_SIZE_DEF,
    parameter int COORD_BITS = acwb_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = acwb_pkg::FRAC_BITS_DEF,
    localparam int TILE_AW   = $clog2((CELL_SIZE + 1) * (CELL_SIZE + 1))
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [acwb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [acwb_pkg::REG_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           operation,
    input  logic [TILE_AW-1:0]             tile_index,
    input  logic [acwb_pkg::CH_W-1:0]      in_red,
    input  logic [acwb_pkg::CH_W-1:0]      in_green,
    input  logic [acwb_pkg::CH_W-1:0]      in_blue,
    input  logic [COORD_BITS-1:0]          dest_x,
    input  logic [COORD_BITS-1:0]          dest_y,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           write_valid,
    output logic [COORD_BITS-1:0]          out_x,
    output logic [COORD_BITS-1:0]          out_y,
    output logic [acwb_pkg::CH_W-1:0]      out_red,
    output logic [acwb_pkg::CH_W-1:0]      out_green,
    output logic [acwb_pkg::CH_W-1:0]      out_blue
);
    import acwb_pkg::*;

    localparam int TILE_DIM   = CELL_SIZE + 1;
    localparam int TILE_DEPTH = TILE_DIM * TILE_DIM;
    localparam int IB         = $clog2(CELL_SIZE + 1);
    localparam int PW         = REG_W + COORD_BITS + 1;   // product width
    localparam int SW         = PW + 2;                   // sum width, never wraps
    localparam logic signed [SW-1:0] LIM = SW'(CELL_SIZE) << FRAC_BITS;

    // configuration registers
    logic signed [REG_W-1:0] scale_xx_reg, scale_xy_reg, offset_x_reg;
    logic signed [REG_W-1:0] scale_yx_reg, scale_yy_reg, offset_y_reg;

    // pipeline control
    logic en, in_xfer, warp_xfer, load_we, tile_we;

    // load path, kept in step with the warp stages a and b
    logic                    ld_a_valid_reg, ld_b_valid_reg;
    logic [TILE_AW-1:0]      ld_a_index_reg, ld_b_index_reg;
    logic [PIX_W-1:0]        ld_a_pix_reg, ld_b_pix_reg;

    // stage a: products
    logic                    a_valid_reg;
    logic [COORD_BITS-1:0]   a_dx_reg, a_dy_reg;
    logic signed [PW-1:0]    a_pxx_reg, a_pxy_reg, a_pyx_reg, a_pyy_reg;
    logic signed [PW-1:0]    a_pxx_next, a_pxy_next, a_pyx_next, a_pyy_next;
    logic signed [COORD_BITS:0] dx_s, dy_s;

    // stage b: source coordinates
    logic                    b_valid_reg;
    logic [COORD_BITS-1:0]   b_dx_reg, b_dy_reg;
    logic signed [SW-1:0]    b_sx_reg, b_sy_reg, b_sx_next, b_sy_next;

    // stage c: range check and tile read
    logic                    c_inside_next;
    logic [IB-1:0]           x0_w, y0_w;
    logic [TILE_AW-1:0]      a00_w, a01_w, a10_w, a11_w;
    logic                    c_valid_reg, c_inside_reg;
    logic [FRAC_BITS-1:0]    c_fx_reg, c_fy_reg;
    logic [COORD_BITS-1:0]   c_dx_reg, c_dy_reg;
    logic [PIX_W-1:0]        p00_w, p01_w, p10_w, p11_w;
    logic [PIX_W-1:0]        load_pix;

    assign en        = !(out_valid && out_stall);
    assign in_stall  = !en;
    assign in_xfer   = in_valid && en;
    assign warp_xfer = in_xfer && (operation == OP_WARP);
    // a load beyond the tile is dropped
    assign load_we   = in_xfer && (operation == OP_LOAD)
                       && ({1'b0, tile_index} < (TILE_AW + 1)'(TILE_DEPTH));
    assign load_pix  = {in_red, in_green, in_blue};
    // the tile write happens at the same step as the read of stage c
    assign tile_we   = ld_b_valid_reg && en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_xx_reg <= SCALE_ONE_RST;
            scale_xy_reg <= '0;
            offset_x_reg <= '0;
            scale_yx_reg <= '0;
            scale_yy_reg <= SCALE_ONE_RST;
            offset_y_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_SCALE_XX: scale_xx_reg <= cfg_data;
                CFG_SCALE_XY: scale_xy_reg <= cfg_data;
                CFG_OFFSET_X: offset_x_reg <= cfg_data;
                CFG_SCALE_YX: scale_yx_reg <= cfg_data;
                CFG_SCALE_YY: scale_yy_reg <= cfg_data;
                CFG_OFFSET_Y: offset_y_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // stage a: four signed products, coordinates taken as non-negative
    always_comb
    begin
        dx_s       = $signed({1'b0, dest_x});
        dy_s       = $signed({1'b0, dest_y});
        a_pxx_next = PW'(scale_xx_reg) * PW'(dx_s);
        a_pxy_next = PW'(scale_xy_reg) * PW'(dy_s);
        a_pyx_next = PW'(scale_yx_reg) * PW'(dx_s);
        a_pyy_next = PW'(scale_yy_reg) * PW'(dy_s);
    end

    // stage b: add the offsets
    always_comb
    begin
        b_sx_next = SW'(a_pxx_reg) + SW'(a_pxy_reg) + SW'(offset_x_reg);
        b_sy_next = SW'(a_pyx_reg) + SW'(a_pyy_reg) + SW'(offset_y_reg);
    end

    // stage c: corner addresses; parked at entry zero when outside the cell
    always_comb
    begin
        c_inside_next = !b_sx_reg[SW-1] && !b_sy_reg[SW-1]
                        && (b_sx_reg < LIM) && (b_sy_reg < LIM);
        x0_w  = b_sx_reg[FRAC_BITS +: IB];
        y0_w  = b_sy_reg[FRAC_BITS +: IB];
        a00_w = c_inside_next ? TILE_AW'(TILE_AW'(y0_w) * TILE_AW'(TILE_DIM) + TILE_AW'(x0_w))
                              : '0;
        a01_w = c_inside_next ? TILE_AW'(a00_w + TILE_AW'(1)) : '0;
        a10_w = c_inside_next ? TILE_AW'(a00_w + TILE_AW'(TILE_DIM)) : '0;
        a11_w = c_inside_next ? TILE_AW'(a10_w + TILE_AW'(1)) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
            c_valid_reg    <= 1'b0;
            ld_a_valid_reg <= 1'b0;
            ld_b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg    <= warp_xfer;
            b_valid_reg    <= a_valid_reg;
            c_valid_reg    <= b_valid_reg;
            ld_a_valid_reg <= load_we;
            ld_b_valid_reg <= ld_a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_dx_reg       <= dest_x;
            a_dy_reg       <= dest_y;
            a_pxx_reg      <= a_pxx_next;
            a_pxy_reg      <= a_pxy_next;
            a_pyx_reg      <= a_pyx_next;
            a_pyy_reg      <= a_pyy_next;
            b_dx_reg       <= a_dx_reg;
            b_dy_reg       <= a_dy_reg;
            b_sx_reg       <= b_sx_next;
            b_sy_reg       <= b_sy_next;
            c_inside_reg   <= c_inside_next;
            c_fx_reg       <= b_sx_reg[FRAC_BITS-1:0];
            c_fy_reg       <= b_sy_reg[FRAC_BITS-1:0];
            c_dx_reg       <= b_dx_reg;
            c_dy_reg       <= b_dy_reg;
            ld_a_index_reg <= tile_index;
            ld_a_pix_reg   <= load_pix;
            ld_b_index_reg <= ld_a_index_reg;
            ld_b_pix_reg   <= ld_a_pix_reg;
        end
    end

    // upper copy serves row y0, lower copy row y0+1; both take every load
    acwb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (TILE_DEPTH)
    ) u_tile_upper (
        .clk     (clk),
        .we      (tile_we),
        .waddr   (ld_b_index_reg),
        .wdata   (ld_b_pix_reg),
        .re      (en),
        .raddr_a (a00_w),
        .raddr_b (a01_w),
        .rdata_a (p00_w),
        .rdata_b (p01_w)
    );

    acwb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (TILE_DEPTH)
    ) u_tile_lower (
        .clk     (clk),
        .we      (tile_we),
        .waddr   (ld_b_index_reg),
        .wdata   (ld_b_pix_reg),
        .re      (en),
        .raddr_a (a10_w),
        .raddr_b (a11_w),
        .rdata_a (p10_w),
        .rdata_b (p11_w)
    );

    acwb_blend #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_blend (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .c_valid     (c_valid_reg),
        .c_inside    (c_inside_reg),
        .c_fx        (c_fx_reg),
        .c_fy        (c_fy_reg),
        .c_dx        (c_dx_reg),
        .c_dy        (c_dy_reg),
        .p00         (p00_w),
        .p01         (p01_w),
        .p10         (p10_w),
        .p11         (p11_w),
        .out_valid   (out_valid),
        .write_valid (write_valid),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_red     (out_red),
        .out_green   (out_green),
        .out_blue    (out_blue)
    );

    `include "affine_cell_warp_bilinear_macros.svh"

    // the input side stalls exactly when a held result blocks the pipeline
    `ACWB_ASSERT_NOW(a_stall_follows_out, 1'b1, in_stall == (out_valid && out_stall),
                     "in_stall mismatch")
    // an accepted warp enters the pipeline
    `ACWB_ASSERT_NEXT(a_warp_enters, warp_xfer, a_valid_reg, "warp transfer lost")
    // a point outside the cell carries black
    `ACWB_ASSERT_NOW(a_outside_black, out_valid && !write_valid,
                     (out_red == '0) && (out_green == '0) && (out_blue == '0),
                     "outside result not zero")

endmodule
